// ----- design/dtt_pkg.sv -----
// Shared types, constants and codes for the deadline timer table.
package dtt_pkg;

	// Table geometry.
	localparam int NUM_TIMERS = 8;
	localparam int ID_BITS    = 4;
	localparam int SLOT_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);
	localparam int TIME_BITS  = 32;

	// Timer kinds as stored in an entry.
	localparam logic [1:0] KIND_ONETIME  = 2'd1;
	localparam logic [1:0] KIND_PERIODIC = 2'd2;

	// Command codes of an input transaction.
	typedef enum logic [2:0] {
		FUNC_ADD     = 3'd0,
		FUNC_DELETE  = 3'd1,
		FUNC_LATER   = 3'd2,
		FUNC_EARLIER = 3'd3,
		FUNC_EXPIRE  = 3'd4
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_FULL        = 3'd1,
		STAT_BAD_KIND    = 3'd2,
		STAT_NOT_FOUND   = 3'd3,
		STAT_EMPTY       = 3'd4,
		STAT_ZERO_PERIOD = 3'd5
	} status_t;

	// Operations broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_NOP,
		CELL_WRITE,
		CELL_CLEAR,
		CELL_ADD_ALL,
		CELL_SUB_ALL,
		CELL_ADD_ONE
	} cell_op_t;

	// Controller state.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_SCAN_C
	} state_t;

	// Broadcast command from the controller to the cells.
	typedef struct packed {
		cell_op_t               op;
		logic [SLOT_BITS-1:0]   slot;
		logic [ID_BITS-1:0]     id;
		logic [1:0]             kind;
		logic [TIME_BITS-1:0]   amount;
	} cmd_t;

	// Running scan result handed from cell to cell.
	typedef struct packed {
		logic                   e_found;
		logic [TIME_BITS-1:0]   e_dl;
		logic [SLOT_BITS-1:0]   e_slot;
		logic [ID_BITS-1:0]     e_id;
		logic [1:0]             e_kind;
		logic                   m_found;
		logic [SLOT_BITS-1:0]   m_slot;
		logic                   f_found;
		logic [SLOT_BITS-1:0]   f_slot;
	} scan_t;

endpackage

// ----- design/dtt_cell.sv -----
// One table entry with its stage of the scan chain.
module dtt_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [dtt_pkg::SLOT_BITS-1:0]     slot,
	input  dtt_pkg::cmd_t                     cmd,
	input  logic [dtt_pkg::ID_BITS-1:0]       key_id,
	input  dtt_pkg::scan_t                    carry_in,
	output dtt_pkg::scan_t                    carry_out
);

	logic                              valid_q;
	logic [dtt_pkg::ID_BITS-1:0]       id_q;
	logic [1:0]                        kind_q;
	logic [dtt_pkg::TIME_BITS-1:0]     dl_q;
	dtt_pkg::scan_t                    carry_d;
	dtt_pkg::scan_t                    carry_q;
	logic                              hit;

	assign hit = (cmd.slot == slot);

	// Valid bit: set by a write, cleared by a clear aimed at this slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				dtt_pkg::CELL_WRITE: begin
					if (hit) valid_q <= 1'b1;
				end
				dtt_pkg::CELL_CLEAR: begin
					if (hit) valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Entry payload and deadline arithmetic, wrapping modulo 2^32.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			dtt_pkg::CELL_WRITE: begin
				if (hit) begin
					id_q   <= cmd.id;
					kind_q <= cmd.kind;
					dl_q   <= cmd.amount;
				end
			end
			dtt_pkg::CELL_ADD_ALL: begin
				if (valid_q) dl_q <= dl_q + cmd.amount;
			end
			dtt_pkg::CELL_SUB_ALL: begin
				if (valid_q) dl_q <= dl_q - cmd.amount;
			end
			dtt_pkg::CELL_ADD_ONE: begin
				if (hit) dl_q <= dl_q + cmd.amount;
			end
			default: begin
			end
		endcase
	end

	// Fold this entry into the running scan. Strict compare keeps the lowest slot on a tie.
	always_comb begin
		carry_d = carry_in;
		if (valid_q && (!carry_in.e_found || (dl_q < carry_in.e_dl))) begin
			carry_d.e_found = 1'b1;
			carry_d.e_dl    = dl_q;
			carry_d.e_slot  = slot;
			carry_d.e_id    = id_q;
			carry_d.e_kind  = kind_q;
		end
		if (valid_q && !carry_in.m_found && (id_q == key_id)) begin
			carry_d.m_found = 1'b1;
			carry_d.m_slot  = slot;
		end
		if (!valid_q && !carry_in.f_found) begin
			carry_d.f_found = 1'b1;
			carry_d.f_slot  = slot;
		end
	end

	// Scan stage register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	assign carry_out = carry_q;

endmodule

// ----- design/deadline_timer_table.sv -----
// Deadline timer table: a chain of timer cells with a command sequencer and result register.
//
// The table holds NUM_TIMERS timers in a row of cells; a scan record ripples through the
// row one cell per clock, and every lookup (identifier match, first free slot, earliest
// deadline) waits for it to pass the whole row. A transaction needs a lookup before its
// update and one after it, plus a third when the earliest deadline has to be caught up
// to now, and one transaction is in work at a time. A new transaction may be accepted
// while the previous result still waits on the output.
// The table is empty after reset and needs no clearing pass.
module deadline_timer_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          func,
	input  logic [dtt_pkg::ID_BITS-1:0]         timer_id,
	input  logic [1:0]                          timer_kind,
	input  logic [dtt_pkg::TIME_BITS-1:0]       deadline,
	input  logic [dtt_pkg::TIME_BITS-1:0]       delta,
	input  logic [dtt_pkg::TIME_BITS-1:0]       period_seconds,
	input  logic [dtt_pkg::TIME_BITS-1:0]       now_seconds,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [dtt_pkg::TIME_BITS-1:0]       alarm_delay,
	output logic [dtt_pkg::ID_BITS-1:0]         earliest_id,
	output logic                                any_armed
);

	dtt_pkg::state_t                   state_q, state_d;
	logic [dtt_pkg::CNT_BITS-1:0]      cnt_q, cnt_d;
	logic [dtt_pkg::CNT_BITS-1:0]      count_q, count_d;
	dtt_pkg::status_t                  stat_q, stat_d;
	dtt_pkg::cmd_t                     cmd;
	dtt_pkg::scan_t                    links [0:dtt_pkg::NUM_TIMERS];
	dtt_pkg::scan_t                    tail;
	logic                              out_load;
	logic                              out_free;
	logic [dtt_pkg::TIME_BITS-1:0]     lag;

	// Latched transaction fields.
	logic [2:0]                        func_q;
	logic [dtt_pkg::ID_BITS-1:0]       id_q;
	logic [1:0]                        kind_q;
	logic [dtt_pkg::TIME_BITS-1:0]     dl_q;
	logic [dtt_pkg::TIME_BITS-1:0]     delta_q;
	logic [dtt_pkg::TIME_BITS-1:0]     period_q;
	logic [dtt_pkg::TIME_BITS-1:0]     now_q;

	// Result register.
	logic                              out_valid_q;
	logic [2:0]                        status_q;
	logic [dtt_pkg::TIME_BITS-1:0]     alarm_q;
	logic [dtt_pkg::ID_BITS-1:0]       earliest_q;
	logic                              armed_q;

	// Row of cells; the scan record enters empty at the head.
	assign links[0] = '0;
	for (genvar i = 0; i < dtt_pkg::NUM_TIMERS; i++) begin : g_cell
		dtt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot      (dtt_pkg::SLOT_BITS'(i)),
			.cmd       (cmd),
			.key_id    (id_q),
			.carry_in  (links[i]),
			.carry_out (links[i+1])
		);
	end
	assign tail = links[dtt_pkg::NUM_TIMERS];

	assign in_ready = (state_q == dtt_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign lag      = now_q - tail.e_dl;

	// Capture the transaction fields on acceptance.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q   <= func;
			id_q     <= timer_id;
			kind_q   <= timer_kind;
			dl_q     <= deadline;
			delta_q  <= delta;
			period_q <= period_seconds;
			now_q    <= now_seconds;
		end
	end

	// Sequencer state, scan counter, entry count and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtt_pkg::ST_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
			stat_q  <= dtt_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			count_q <= count_d;
			stat_q  <= stat_d;
		end
	end

	// Next state, cell commands and status. Each scan state waits until the record
	// has passed the whole row, then acts on the tail result.
	always_comb begin
		state_d    = state_q;
		cnt_d      = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
		count_d    = count_q;
		stat_d     = stat_q;
		cmd        = '0;
		cmd.op     = dtt_pkg::CELL_NOP;
		cmd.id     = id_q;
		cmd.kind   = kind_q;
		out_load   = 1'b0;
		unique case (state_q)
			dtt_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					state_d = dtt_pkg::ST_SCAN_A;
					cnt_d   = dtt_pkg::CNT_BITS'(dtt_pkg::NUM_TIMERS);
				end
			end
			dtt_pkg::ST_SCAN_A: begin
				if (cnt_q == '0) begin
					state_d = dtt_pkg::ST_SCAN_B;
					cnt_d   = dtt_pkg::CNT_BITS'(dtt_pkg::NUM_TIMERS);
					stat_d  = dtt_pkg::STAT_OK;
					unique case (func_q)
						dtt_pkg::FUNC_ADD: begin
							if (kind_q != dtt_pkg::KIND_ONETIME &&
							    kind_q != dtt_pkg::KIND_PERIODIC) begin
								stat_d = dtt_pkg::STAT_BAD_KIND;
							end else if (tail.m_found) begin
								cmd.op     = dtt_pkg::CELL_WRITE;
								cmd.slot   = tail.m_slot;
								cmd.amount = dl_q;
							end else if (tail.f_found) begin
								cmd.op     = dtt_pkg::CELL_WRITE;
								cmd.slot   = tail.f_slot;
								cmd.amount = dl_q;
								count_d    = count_q + 1'b1;
							end else begin
								stat_d = dtt_pkg::STAT_FULL;
							end
						end
						dtt_pkg::FUNC_DELETE: begin
							if (count_q == '0) begin
								stat_d = dtt_pkg::STAT_EMPTY;
							end else if (!tail.m_found) begin
								stat_d = dtt_pkg::STAT_NOT_FOUND;
							end else begin
								cmd.op   = dtt_pkg::CELL_CLEAR;
								cmd.slot = tail.m_slot;
								count_d  = count_q - 1'b1;
							end
						end
						dtt_pkg::FUNC_LATER: begin
							cmd.op     = dtt_pkg::CELL_ADD_ALL;
							cmd.amount = delta_q;
						end
						dtt_pkg::FUNC_EARLIER: begin
							cmd.op     = dtt_pkg::CELL_SUB_ALL;
							cmd.amount = delta_q;
						end
						dtt_pkg::FUNC_EXPIRE: begin
							if (!tail.e_found) begin
								stat_d = dtt_pkg::STAT_EMPTY;
							end else if (tail.e_kind == dtt_pkg::KIND_PERIODIC) begin
								if (period_q == '0) begin
									stat_d = dtt_pkg::STAT_ZERO_PERIOD;
								end else begin
									cmd.op     = dtt_pkg::CELL_ADD_ONE;
									cmd.slot   = tail.e_slot;
									cmd.amount = period_q;
								end
							end else begin
								cmd.op   = dtt_pkg::CELL_CLEAR;
								cmd.slot = tail.e_slot;
								count_d  = count_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			dtt_pkg::ST_SCAN_B: begin
				if (cnt_q == '0) begin
					if (tail.e_found && (tail.e_dl <= now_q)) begin
						// Catch up: push every deadline by max(1, now - earliest).
						cmd.op     = dtt_pkg::CELL_ADD_ALL;
						cmd.amount = (lag == '0) ? dtt_pkg::TIME_BITS'(1) : lag;
						state_d    = dtt_pkg::ST_SCAN_C;
						cnt_d      = dtt_pkg::CNT_BITS'(dtt_pkg::NUM_TIMERS);
					end else if (out_free) begin
						out_load = 1'b1;
						state_d  = dtt_pkg::ST_IDLE;
					end
				end
			end
			dtt_pkg::ST_SCAN_C: begin
				if (cnt_q == '0 && out_free) begin
					out_load = 1'b1;
					state_d  = dtt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dtt_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload from the final scan.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q   <= stat_q;
			alarm_q    <= tail.e_found ? (tail.e_dl - now_q) : '0;
			earliest_q <= tail.e_found ? tail.e_id : '0;
			armed_q    <= tail.e_found;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign alarm_delay = alarm_q;
	assign earliest_id = earliest_q;
	assign any_armed   = armed_q;

`ifndef SYNTHESIS
	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dtt_pkg::CNT_BITS'(dtt_pkg::NUM_TIMERS))
		else $error("entry count exceeds table size");

	// Cells are only commanded while a transaction is in work.
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != dtt_pkg::CELL_NOP) |-> (state_q != dtt_pkg::ST_IDLE))
		else $error("cell command issued while idle");

	// The reported armed flag agrees with the entry count.
	a_armed_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (tail.e_found == (count_q != '0)))
		else $error("scan result disagrees with entry count");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");
`endif

endmodule
